// File: hw/rtl/crp_pkg.sv
// Package: sizes, constants and helper functions of the framed request parser.
`default_nettype none
package crp_pkg;
    localparam int BUFFER_BYTES = 226;
    localparam int MAX_PAYLOAD  = 104;
    localparam int LEGACY_LIMIT = 100;
    localparam int HDR_LEN      = 7;
    localparam int CRC_LEN      = 2;
    localparam int IDLE_RESET   = 1000;

    localparam int PTR_W  = $clog2(BUFFER_BYTES);
    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
    localparam int OFF_W  = $clog2(MAX_PAYLOAD + HDR_LEN + CRC_LEN + 1);
    localparam int CNT_W  = (OFF_W > FILL_W) ? OFF_W : FILL_W;
    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);

    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_POLL = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    localparam logic [1:0] REG_IDLE_LIMIT = 2'd0;
    localparam logic [1:0] REG_ALLOW_REC  = 2'd1;
    localparam logic [1:0] REG_VERSION    = 2'd2;

    localparam logic [7:0] MAGIC_S = 8'h53;
    localparam logic [7:0] MAGIC_R = 8'h52;

    localparam logic [7:0] CMD_FIRST   = 8'd1;
    localparam logic [7:0] CMD_BIG     = 8'd3;
    localparam logic [7:0] CMD_SHORT   = 8'd5;
    localparam logic [7:0] CMD_NODATA  = 8'd6;
    localparam logic [7:0] CMD_RECOVER = 8'd7;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] r;
        r = c ^ {d, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if (r[15])
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [15:0] cmd_limit(input logic [7:0] c);
        if (c == CMD_SHORT)
            return 16'd1;
        else if (c == CMD_NODATA || c == CMD_RECOVER)
            return 16'd0;
        else if (c == CMD_BIG)
            return 16'(MAX_PAYLOAD);
        else
            return 16'(LEGACY_LIMIT);
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/crc_framed_request_parser.sv
// Top level: byte buffer with CRC-16/CCITT-FALSE framed request parser.
//
// Input stream: s_tuser carries func (push, poll, tick), s_tdata the byte.
// A push or a tick leaves s_tready high for the next word.
// A poll is worked by a sequencer that reads the circular byte buffer one
// byte at a time through its single registered read port, feeding one
// byte-wide CRC step per byte.
// Output stream: one word per result; tuser is kind, tlast marks the final
// word of a poll. Results sit in an output register; a stalled receiver
// holds the word and the sequencer waits before loading the next one.
// Configuration writes (cfg_we) are taken at any edge, meant for idle time.
// Reset empties the buffer, clears the idle counter and restores register
// defaults; buffer contents are left as they were.
`default_nettype none
module crc_framed_request_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // command[2:0], sequence_res[10:3],
                                        // payload_len[17:11], chunk_index[21:18],
                                        // chunk_data[85:22], zero[87:86]
    output logic             m_tuser,   // kind
    output logic             m_tlast,   // last
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    import crp_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SCAN_RD  = 4'd1;
    localparam logic [3:0] ST_SCAN_CHK = 4'd2;
    localparam logic [3:0] ST_HDR_RD   = 4'd3;
    localparam logic [3:0] ST_HDR_CHK  = 4'd4;
    localparam logic [3:0] ST_HDR_EVAL = 4'd5;
    localparam logic [3:0] ST_CRC_RD   = 4'd6;
    localparam logic [3:0] ST_CRC_CHK  = 4'd7;
    localparam logic [3:0] ST_CHK_RD   = 4'd8;
    localparam logic [3:0] ST_CHK_CHK  = 4'd9;
    localparam logic [3:0] ST_EMIT     = 4'd10;
    localparam logic [3:0] ST_NOFRM    = 4'd11;

    function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] h,
                                              input logic [CNT_W-1:0] o);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(h) + (CNT_W+1)'(o);
        if (s >= (CNT_W+1)'(BUFFER_BYTES))
            s = s - (CNT_W+1)'(BUFFER_BYTES);
        return s[PTR_W-1:0];
    endfunction

    logic [7:0] mem [BUFFER_BYTES];

    logic [3:0]        state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [15:0]       idle_reg, idle_next;
    logic [CNT_W-1:0]  off_reg, off_next;
    logic              prev_s_reg, prev_s_next;
    logic [7:0]        ver_reg, ver_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [15:0]       len_reg, len_next;
    logic [7:0]        seq_reg, seq_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        crc_lo_reg, crc_lo_next;
    logic [63:0]       chunk_reg, chunk_next;
    logic [3:0]        j_reg, j_next;
    logic [3:0]        k_reg, k_next;
    logic [7:0]        rd_data_reg;

    logic              ov_reg, ov_next;
    logic              okind_reg, okind_next;
    logic              olast_reg, olast_next;
    logic [2:0]        ocmd_reg, ocmd_next;
    logic [7:0]        oseq_reg, oseq_next;
    logic [6:0]        olen_reg, olen_next;
    logic [3:0]        oidx_reg, oidx_next;
    logic [63:0]       odata_reg, odata_next;

    logic [15:0]       idle_limit_reg;
    logic              allow_rec_reg;
    logic [7:0]        version_reg;

    logic [PTR_W-1:0]  rd_addr;
    logic              we;
    logic [PTR_W-1:0]  wr_addr;
    logic              can_load;
    logic              in_acc;
    logic [CNT_W-1:0]  fill_w;
    logic [CNT_W-1:0]  flen;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  len_w;
    logic [CNT_W-1:0]  m_w;
    logic              hdr_ok;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign can_load = !ov_reg || m_tready;
    assign rd_addr  = wrap(head_reg, off_reg);
    assign fill_w   = CNT_W'(fill_reg);
    assign len_w    = CNT_W'(len_reg[LEN_W-1:0]);
    assign flen     = len_w + CNT_W'(HDR_LEN + CRC_LEN);
    assign pos      = off_reg - CNT_W'(HDR_LEN);
    assign m_w      = off_reg - CNT_W'(1);
    assign hdr_ok   = (ver_reg == version_reg)
                    && ((cmd_reg >= CMD_FIRST && cmd_reg <= CMD_NODATA)
                        || (cmd_reg == CMD_RECOVER && allow_rec_reg))
                    && (len_reg <= cmd_limit(cmd_reg));

    assign m_tvalid = ov_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {2'b00, odata_reg, oidx_reg, olen_reg, oseq_reg, ocmd_reg};

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        idle_next   = idle_reg;
        off_next    = off_reg;
        prev_s_next = prev_s_reg;
        ver_next    = ver_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        seq_next    = seq_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        chunk_next  = chunk_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        ov_next     = ov_reg && !m_tready;
        okind_next  = okind_reg;
        olast_next  = olast_reg;
        ocmd_next   = ocmd_reg;
        oseq_next   = oseq_reg;
        olen_next   = olen_reg;
        oidx_next   = oidx_reg;
        odata_next  = odata_reg;
        we          = 1'b0;
        wr_addr     = wrap(head_reg, fill_w);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (s_tuser)
                        FUNC_PUSH:
                        begin
                            idle_next = '0;
                            we = 1'b1;
                            if (fill_reg >= FILL_W'(BUFFER_BYTES))
                            begin
                                wr_addr   = head_reg;
                                head_next = wrap(head_reg, CNT_W'(1));
                            end
                            else
                                fill_next = fill_reg + FILL_W'(1);
                        end
                        FUNC_POLL:
                        begin
                            off_next    = '0;
                            prev_s_next = 1'b0;
                            state_next  = ST_SCAN_RD;
                        end
                        FUNC_TICK:
                        begin
                            if (idle_reg != 16'hFFFF)
                                idle_next = idle_reg + 16'd1;
                            if (fill_reg != '0 && idle_next >= idle_limit_reg)
                                fill_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                if (off_reg == fill_w)
                begin
                    if (prev_s_reg)
                    begin
                        head_next = wrap(head_reg, fill_w - CNT_W'(1));
                        fill_next = FILL_W'(1);
                    end
                    else
                        fill_next = '0;
                    state_next = ST_NOFRM;
                end
                else
                    state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (prev_s_reg && rd_data_reg == MAGIC_R)
                begin
                    head_next = wrap(head_reg, m_w);
                    fill_next = fill_reg - m_w[FILL_W-1:0];
                    if (fill_w - m_w < CNT_W'(HDR_LEN))
                        state_next = ST_NOFRM;
                    else
                    begin
                        off_next   = CNT_W'(2);
                        state_next = ST_HDR_RD;
                    end
                end
                else
                begin
                    prev_s_next = (rd_data_reg == MAGIC_S);
                    off_next    = off_reg + CNT_W'(1);
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_HDR_RD:
                state_next = ST_HDR_CHK;
            ST_HDR_CHK:
            begin
                case (off_reg[2:0])
                    3'd2: ver_next = rd_data_reg;
                    3'd3: cmd_next = rd_data_reg;
                    3'd4: len_next[7:0] = rd_data_reg;
                    3'd5: len_next[15:8] = rd_data_reg;
                    default: seq_next = rd_data_reg;
                endcase
                off_next = off_reg + CNT_W'(1);
                state_next = (off_reg == CNT_W'(HDR_LEN - 1)) ? ST_HDR_EVAL : ST_HDR_RD;
            end
            ST_HDR_EVAL:
            begin
                if (!hdr_ok)
                begin
                    head_next   = wrap(head_reg, CNT_W'(1));
                    fill_next   = fill_reg - FILL_W'(1);
                    off_next    = '0;
                    prev_s_next = 1'b0;
                    state_next  = ST_SCAN_RD;
                end
                else if (fill_w < flen)
                    state_next = ST_NOFRM;
                else
                begin
                    crc_next   = CRC_INIT;
                    off_next   = '0;
                    state_next = ST_CRC_RD;
                end
            end
            ST_CRC_RD:
                state_next = ST_CRC_CHK;
            ST_CRC_CHK:
            begin
                off_next   = off_reg + CNT_W'(1);
                state_next = ST_CRC_RD;
                if (off_reg < flen - CNT_W'(CRC_LEN))
                    crc_next = crc_byte(crc_reg, rd_data_reg);
                else if (off_reg == flen - CNT_W'(CRC_LEN))
                    crc_lo_next = rd_data_reg;
                else if ({rd_data_reg, crc_lo_reg} == crc_reg)
                begin
                    off_next   = CNT_W'(HDR_LEN);
                    chunk_next = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = ST_CHK_RD;
                end
                else
                begin
                    head_next   = wrap(head_reg, CNT_W'(1));
                    fill_next   = fill_reg - FILL_W'(1);
                    off_next    = '0;
                    prev_s_next = 1'b0;
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_CHK_RD:
                state_next = (j_reg == 4'd8 || pos >= len_w) ? ST_EMIT : ST_CHK_CHK;
            ST_CHK_CHK:
            begin
                chunk_next[j_reg[2:0]*8 +: 8] = rd_data_reg;
                j_next     = j_reg + 4'd1;
                off_next   = off_reg + CNT_W'(1);
                state_next = ST_CHK_RD;
            end
            ST_EMIT:
            begin
                if (can_load)
                begin
                    ov_next    = 1'b1;
                    okind_next = 1'b1;
                    ocmd_next  = cmd_reg[2:0];
                    oseq_next  = seq_reg;
                    olen_next  = len_reg[6:0];
                    oidx_next  = k_reg;
                    odata_next = chunk_reg;
                    olast_next = (pos >= len_w);
                    if (pos >= len_w)
                    begin
                        head_next  = wrap(head_reg, flen);
                        fill_next  = fill_reg - flen[FILL_W-1:0];
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 4'd1;
                        j_next     = '0;
                        chunk_next = '0;
                        state_next = ST_CHK_RD;
                    end
                end
            end
            ST_NOFRM:
            begin
                if (can_load)
                begin
                    ov_next    = 1'b1;
                    okind_next = 1'b0;
                    ocmd_next  = '0;
                    oseq_next  = '0;
                    olen_next  = '0;
                    oidx_next  = '0;
                    odata_next = '0;
                    olast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= s_tdata;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            fill_reg       <= '0;
            idle_reg       <= '0;
            ov_reg         <= 1'b0;
            idle_limit_reg <= 16'(IDLE_RESET);
            allow_rec_reg  <= 1'b1;
            version_reg    <= 8'd1;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            idle_reg  <= idle_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IDLE_LIMIT: idle_limit_reg <= cfg_wdata;
                    REG_ALLOW_REC:  allow_rec_reg  <= cfg_wdata[0];
                    REG_VERSION:    version_reg    <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg    <= off_next;
        prev_s_reg <= prev_s_next;
        ver_reg    <= ver_next;
        cmd_reg    <= cmd_next;
        len_reg    <= len_next;
        seq_reg    <= seq_next;
        crc_reg    <= crc_next;
        crc_lo_reg <= crc_lo_next;
        chunk_reg  <= chunk_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        okind_reg  <= okind_next;
        olast_reg  <= olast_next;
        ocmd_reg   <= ocmd_next;
        oseq_reg   <= oseq_next;
        olen_reg   <= olen_next;
        oidx_reg   <= oidx_next;
        odata_reg  <= odata_next;
    end
endmodule
`default_nettype wire

// File: hw/rtl/crp_checker.sv
// Checker: port-level assertions for the framed request parser, with bind.
`default_nettype none
module crp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [87:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_nofrm_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("no-frame word without last");

    a_nofrm_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("no-frame word carries data");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[87:86] == 2'b00)
        else $error("padding bits set");
endmodule

bind crc_framed_request_parser crp_checker u_crp_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire
